### sv/dvt_pkg.sv
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants for the buck duty voltage tracker.
// ----------------------------------------------------------------------------
package dvt_pkg;

	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 13;
	localparam int VOLT_W     = 15;
	localparam int VOLT_MAX   = 32767;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [GAIN_W-1:0] OUT_GAIN_RST      = 16'd15102;
	localparam logic [GAIN_W-1:0] IN_GAIN_RST       = 16'd39366;
	localparam logic [VOLT_W-1:0] MPPT_SETPOINT_RST = 15'd3144;
	localparam logic [VOLT_W-1:0] OUT_REFERENCE_RST = 15'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUT_GAIN      = 3'd0,
		REG_IN_GAIN       = 3'd1,
		REG_MPPT_SETPOINT = 3'd2,
		REG_OUT_REFERENCE = 3'd3,
		REG_TRACK_MODE    = 3'd4,
		REG_HOLD_ON_EQUAL = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] out_gain;
		logic [GAIN_W-1:0] in_gain;
		logic [VOLT_W-1:0] mppt_setpoint;
		logic [VOLT_W-1:0] out_reference;
		logic              track_mode;
		logic              hold_on_equal;
	} cfg_t;

endpackage

### sv/buck_duty_voltage_tracker.sv
// ----------------------------------------------------------------------------
// buck_duty_voltage_tracker
// Duty controller for one buck channel: scales ADC sample pairs, slews the
// filtered voltages by one count and steps the PWM duty by one count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per ADC sample pair.
//   Output channel (out_valid/out_ready) returns one result per request: the
//   new duty and both filtered voltages, all taken after that request's step.
//   Configuration is a write-only indexed port (cfg_wen/cfg_index/cfg_wdata);
//   write it only while no request is in flight.
//   An accepted request loads the multiply/saturate register, then the slew
//   and duty registers, which are the result; while the receiver stalls,
//   it waits in the multiply/saturate register.
//   Throughput is one request per cycle while out_ready stays high; the slew
//   and duty registers feed back on themselves, which sets that rate.
//   When the receiver stalls, the scale stage still takes one more request;
//   in_ready drops once both stages hold unsent work.
//   Reset clears both filtered voltages to 0, sets duty to DUTY_MAX and loads
//   the configuration defaults.
// ----------------------------------------------------------------------------
module buck_duty_voltage_tracker #(
	parameter int ADC_BITS = 12,
	parameter int DUTY_MAX = 1023,
	localparam int DUTY_W  = $clog2(DUTY_MAX + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ADC_BITS-1:0]             raw_out_sample,
	input  logic [ADC_BITS-1:0]             raw_in_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [DUTY_W-1:0]               duty,
	output logic [dvt_pkg::VOLT_W-1:0]      filtered_out_voltage,
	output logic [dvt_pkg::VOLT_W-1:0]      filtered_in_voltage,
	input  logic                            cfg_wen,
	input  logic [dvt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dvt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	dvt_pkg::cfg_t              cfg;
	logic                       valid_s1;
	logic [dvt_pkg::VOLT_W-1:0] out_scaled_s1, in_scaled_s1;
	logic                       advance;
	logic                       load;

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance || !valid_s1;
	assign load     = in_valid && in_ready;

	dvt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dvt_scale_stage #(
		.ADC_BITS (ADC_BITS)
	) u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.take           (advance),
		.raw_out_sample (raw_out_sample),
		.raw_in_sample  (raw_in_sample),
		.out_gain       (cfg.out_gain),
		.in_gain        (cfg.in_gain),
		.valid_s1       (valid_s1),
		.out_scaled_s1  (out_scaled_s1),
		.in_scaled_s1   (in_scaled_s1)
	);

	dvt_track_stage #(
		.DUTY_MAX (DUTY_MAX),
		.DUTY_W   (DUTY_W)
	) u_track (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (valid_s1),
		.advance              (advance),
		.out_scaled_s1        (out_scaled_s1),
		.in_scaled_s1         (in_scaled_s1),
		.cfg                  (cfg),
		.out_valid            (out_valid),
		.duty                 (duty),
		.filtered_out_voltage (filtered_out_voltage),
		.filtered_in_voltage  (filtered_in_voltage)
	);

endmodule

### sv/dvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// dvt_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module dvt_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [dvt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dvt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output dvt_pkg::cfg_t                   cfg
);

	dvt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_gain      <= dvt_pkg::OUT_GAIN_RST;
			cfg_q.in_gain       <= dvt_pkg::IN_GAIN_RST;
			cfg_q.mppt_setpoint <= dvt_pkg::MPPT_SETPOINT_RST;
			cfg_q.out_reference <= dvt_pkg::OUT_REFERENCE_RST;
			cfg_q.track_mode    <= 1'b0;
			cfg_q.hold_on_equal <= 1'b1;
		end else if (cfg_wen) begin
			unique case (dvt_pkg::cfg_reg_t'(cfg_index))
				dvt_pkg::REG_OUT_GAIN:      cfg_q.out_gain      <= cfg_wdata;
				dvt_pkg::REG_IN_GAIN:       cfg_q.in_gain       <= cfg_wdata;
				dvt_pkg::REG_MPPT_SETPOINT: cfg_q.mppt_setpoint <= cfg_wdata[dvt_pkg::VOLT_W-1:0];
				dvt_pkg::REG_OUT_REFERENCE: cfg_q.out_reference <= cfg_wdata[dvt_pkg::VOLT_W-1:0];
				dvt_pkg::REG_TRACK_MODE:    cfg_q.track_mode    <= cfg_wdata[0];
				dvt_pkg::REG_HOLD_ON_EQUAL: cfg_q.hold_on_equal <= cfg_wdata[0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/dvt_scale_stage.sv
// ----------------------------------------------------------------------------
// dvt_scale_stage
// First stage: scales both raw samples by their Q3.13 gains and saturates.
// ----------------------------------------------------------------------------
module dvt_scale_stage #(
	parameter int ADC_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         take,
	input  logic [ADC_BITS-1:0]          raw_out_sample,
	input  logic [ADC_BITS-1:0]          raw_in_sample,
	input  logic [dvt_pkg::GAIN_W-1:0]   out_gain,
	input  logic [dvt_pkg::GAIN_W-1:0]   in_gain,
	output logic                         valid_s1,
	output logic [dvt_pkg::VOLT_W-1:0]   out_scaled_s1,
	output logic [dvt_pkg::VOLT_W-1:0]   in_scaled_s1
);

	localparam int PROD_W = ADC_BITS + dvt_pkg::GAIN_W;
	localparam int SHR_W  = PROD_W - dvt_pkg::GAIN_FRAC;

	logic [PROD_W-1:0]         out_prod, in_prod;
	logic [SHR_W-1:0]          out_shr, in_shr;
	logic [dvt_pkg::VOLT_W-1:0] out_sat, in_sat;

	always_comb begin
		out_prod = PROD_W'(raw_out_sample) * PROD_W'(out_gain);
		in_prod  = PROD_W'(raw_in_sample) * PROD_W'(in_gain);
		out_shr  = out_prod[PROD_W-1:dvt_pkg::GAIN_FRAC];
		in_shr   = in_prod[PROD_W-1:dvt_pkg::GAIN_FRAC];
		out_sat  = (32'(out_shr) > 32'(dvt_pkg::VOLT_MAX)) ?
			dvt_pkg::VOLT_W'(dvt_pkg::VOLT_MAX) : dvt_pkg::VOLT_W'(out_shr);
		in_sat   = (32'(in_shr) > 32'(dvt_pkg::VOLT_MAX)) ?
			dvt_pkg::VOLT_W'(dvt_pkg::VOLT_MAX) : dvt_pkg::VOLT_W'(in_shr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_scaled_s1 <= out_sat;
			in_scaled_s1  <= in_sat;
		end
	end

endmodule

### sv/dvt_track_stage.sv
// ----------------------------------------------------------------------------
// dvt_track_stage
// Second stage: one-count slew of both filtered voltages, then duty stepping.
// ----------------------------------------------------------------------------
module dvt_track_stage #(
	parameter int DUTY_MAX = 1023,
	parameter int DUTY_W   = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         advance,
	input  logic [dvt_pkg::VOLT_W-1:0]   out_scaled_s1,
	input  logic [dvt_pkg::VOLT_W-1:0]   in_scaled_s1,
	input  dvt_pkg::cfg_t                cfg,
	output logic                         out_valid,
	output logic [DUTY_W-1:0]            duty,
	output logic [dvt_pkg::VOLT_W-1:0]   filtered_out_voltage,
	output logic [dvt_pkg::VOLT_W-1:0]   filtered_in_voltage
);

	localparam logic [DUTY_W-1:0] DutyTop  = DUTY_W'(DUTY_MAX);
	localparam logic [DUTY_W-1:0] DutyStep = DUTY_W'(1);
	localparam logic [dvt_pkg::VOLT_W-1:0] VoltStep = dvt_pkg::VOLT_W'(1);

	logic [dvt_pkg::VOLT_W-1:0] out_trk_q, in_trk_q;
	logic [DUTY_W-1:0]          duty_q;
	logic                       valid_q;
	logic [dvt_pkg::VOLT_W-1:0] out_trk_nxt, in_trk_nxt;
	logic [DUTY_W-1:0]          duty_nxt;
	logic                       go_up, go_down;

	always_comb begin
		if (out_scaled_s1 > out_trk_q)
			out_trk_nxt = out_trk_q + VoltStep;
		else if (out_scaled_s1 < out_trk_q)
			out_trk_nxt = out_trk_q - VoltStep;
		else
			out_trk_nxt = out_trk_q;

		if (in_scaled_s1 > in_trk_q)
			in_trk_nxt = in_trk_q + VoltStep;
		else if (in_scaled_s1 < in_trk_q)
			in_trk_nxt = in_trk_q - VoltStep;
		else
			in_trk_nxt = in_trk_q;

		// tracking: below setpoint raises duty; equality decrements unless held
		if (cfg.track_mode) begin
			go_up   = in_trk_nxt < cfg.mppt_setpoint;
			go_down = (in_trk_nxt > cfg.mppt_setpoint) ||
				((in_trk_nxt == cfg.mppt_setpoint) && !cfg.hold_on_equal);
		end else begin
			go_up   = out_trk_nxt > cfg.out_reference;
			go_down = out_trk_nxt < cfg.out_reference;
		end

		duty_nxt = duty_q;
		if (go_up && (duty_q < DutyTop))
			duty_nxt = duty_q + DutyStep;
		else if (go_down && (duty_q != '0))
			duty_nxt = duty_q - DutyStep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			out_trk_q <= '0;
			in_trk_q  <= '0;
			duty_q    <= DutyTop;
		end else if (advance) begin
			valid_q <= step;
			if (step) begin
				out_trk_q <= out_trk_nxt;
				in_trk_q  <= in_trk_nxt;
				duty_q    <= duty_nxt;
			end
		end
	end

	assign out_valid            = valid_q;
	assign duty                 = duty_q;
	assign filtered_out_voltage = out_trk_q;
	assign filtered_in_voltage  = in_trk_q;

endmodule
